// ----- design/usv_pkg.sv -----
// Package with the byte class type and queue sizing shared by the validator modules.
`timescale 1ns / 1ps
`default_nettype none

package usv_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [2:0] {
    LEAD_ASCII = 3'd0,
    LEAD_TWO   = 3'd1,
    LEAD_THREE = 3'd2,
    LEAD_FOUR  = 3'd3,
    LEAD_BAD   = 3'd4
  } lead_kind_e;

  typedef enum logic [2:0] {
    SPEC_NONE = 3'd0,
    SPEC_E0   = 3'd1,
    SPEC_ED   = 3'd2,
    SPEC_EF   = 3'd3,
    SPEC_F0   = 3'd4,
    SPEC_F4   = 3'd5
  } special_e;

  typedef struct packed {
    logic       is_zero;
    logic       is_cont;
    lead_kind_e lead;
    special_e   special;
    logic       hi3_80;
    logic       hi3_a0;
    logic       hi4_80;
    logic       gt_8f;
    logic       be_bf;
    logic       is_bf;
  } byte_class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ----- design/utf8_string_validator_unit.sv -----
// Top level of the strict UTF-8 string validator: classifier, queue and checker.
//
//   Channel  Direction  Handshake                Payload
//   in       input      in_valid_i / in_stall_o  byte_value_i[7:0]
//   out      output     out_valid_o / out_stall_i string_valid_o
//
// One byte is accepted per cycle while the queue is not full; a terminator beat passes
// through the queue and then the output register before its verdict is shown.
// Reset clears the queue pointers, the sequence state and the output valid at once.
// A stall on the output holds back only terminator beats at the head of the queue;
// the input stalls when the queue of QueueDepth beats is full.
`timescale 1ns / 1ps
`default_nettype none

module utf8_string_validator_unit
  import usv_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       string_valid_o
);

  byte_class_t   front_cls;
  byte_class_t   head_cls;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  logic          back_stall;

  assign in_stall_o = q_status.full;
  assign push       = in_valid_i && !q_status.full;
  assign pop        = !q_status.empty && !back_stall;

  usv_classify u_classify (
    .byte_value_i (byte_value_i),
    .cls_o        (front_cls)
  );

  usv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cls_i (front_cls),
    .pop_i      (pop),
    .pop_cls_o  (head_cls),
    .status_o   (q_status)
  );

  usv_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (!q_status.empty),
    .in_cls_i       (head_cls),
    .in_stall_o     (back_stall),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .string_valid_o (string_valid_o)
  );

`ifndef NO_ASSERTIONS
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_status.empty)
    else $error("accepted beat did not reach the queue");

  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && q_status.empty) |=> !out_valid_o)
    else $error("result appeared without a terminator beat");
`endif

endmodule

`default_nettype wire

// ----- design/usv_classify.sv -----
// Front end that sorts each incoming byte into its UTF-8 class flags.
`timescale 1ns / 1ps
`default_nettype none

module usv_classify
  import usv_pkg::*;
(
  input  logic [7:0]  byte_value_i,
  output byte_class_t cls_o
);

  logic [7:0] b;

  assign b = byte_value_i;

  always_comb begin
    cls_o         = '0;
    cls_o.is_zero = (b == 8'h00);
    cls_o.is_cont = ((b & 8'hc0) == 8'h80);
    cls_o.hi3_80  = ((b & 8'he0) == 8'h80);
    cls_o.hi3_a0  = ((b & 8'he0) == 8'ha0);
    cls_o.hi4_80  = ((b & 8'hf0) == 8'h80);
    cls_o.gt_8f   = (b > 8'h8f);
    cls_o.be_bf   = ((b & 8'hfe) == 8'hbe);
    cls_o.is_bf   = (b == 8'hbf);

    priority if (b < 8'h80) begin
      cls_o.lead = LEAD_ASCII;
    end else if ((b & 8'he0) == 8'hc0) begin
      cls_o.lead = ((b & 8'hfe) == 8'hc0) ? LEAD_BAD : LEAD_TWO;
    end else if ((b & 8'hf0) == 8'he0) begin
      cls_o.lead = LEAD_THREE;
    end else if ((b & 8'hf8) == 8'hf0) begin
      cls_o.lead = (b > 8'hf4) ? LEAD_BAD : LEAD_FOUR;
    end else begin
      cls_o.lead = LEAD_BAD;
    end

    unique case (b)
      8'he0:   cls_o.special = SPEC_E0;
      8'hed:   cls_o.special = SPEC_ED;
      8'hef:   cls_o.special = SPEC_EF;
      8'hf0:   cls_o.special = SPEC_F0;
      8'hf4:   cls_o.special = SPEC_F4;
      default: cls_o.special = SPEC_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/usv_queue.sv -----
// Short queue of classified bytes between the front end and the checker.
`timescale 1ns / 1ps
`default_nettype none

module usv_queue
  import usv_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  byte_class_t   push_cls_i,
  input  logic          pop_i,
  output byte_class_t   pop_cls_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  byte_class_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_cls_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cls_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/usv_check.sv -----
// Back end that tracks the sequence state and registers the verdict for each string.
`timescale 1ns / 1ps
`default_nettype none

module usv_check
  import usv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  byte_class_t in_cls_i,
  output logic        in_stall_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        string_valid_o
);

  logic [1:0] rem_q, rem_d;
  logic       first_q, first_d;
  special_e   lead_q, lead_d;
  logic       ef_bf_q, ef_bf_d;
  logic       failed_q, failed_d;
  logic       out_valid_q, out_valid_d;
  logic       string_valid_q, string_valid_d;
  logic       take;
  logic       bad_first;
  byte_class_t c;

  assign c           = in_cls_i;
  assign in_stall_o  = c.is_zero && out_valid_q && out_stall_i;
  assign take        = in_valid_i && !in_stall_o;

  assign bad_first = ((lead_q == SPEC_E0) && c.hi3_80) ||
                     ((lead_q == SPEC_ED) && c.hi3_a0) ||
                     ((lead_q == SPEC_F0) && c.hi4_80) ||
                     ((lead_q == SPEC_F4) && c.gt_8f);

  always_comb begin
    rem_d          = rem_q;
    first_d        = first_q;
    lead_d         = lead_q;
    ef_bf_d        = ef_bf_q;
    failed_d       = failed_q;
    string_valid_d = string_valid_q;
    out_valid_d    = out_stall_i ? out_valid_q : 1'b0;

    if (take) begin
      priority if (c.is_zero) begin
        out_valid_d    = 1'b1;
        string_valid_d = !failed_q && (rem_q == 2'd0);
        rem_d          = 2'd0;
        first_d        = 1'b0;
        lead_d         = SPEC_NONE;
        ef_bf_d        = 1'b0;
        failed_d       = 1'b0;
      end else if (failed_q) begin
        failed_d = 1'b1;
      end else if (rem_q == 2'd0) begin
        unique case (c.lead)
          LEAD_ASCII: begin
            rem_d = 2'd0;
          end
          LEAD_TWO: begin
            rem_d   = 2'd1;
            first_d = 1'b1;
            lead_d  = c.special;
            ef_bf_d = 1'b0;
          end
          LEAD_THREE: begin
            rem_d   = 2'd2;
            first_d = 1'b1;
            lead_d  = c.special;
            ef_bf_d = 1'b0;
          end
          LEAD_FOUR: begin
            rem_d   = 2'd3;
            first_d = 1'b1;
            lead_d  = c.special;
            ef_bf_d = 1'b0;
          end
          default: begin
            rem_d    = 2'd0;
            first_d  = 1'b0;
            lead_d   = SPEC_NONE;
            ef_bf_d  = 1'b0;
            failed_d = 1'b1;
          end
        endcase
      end else if (!c.is_cont || (first_q && bad_first) ||
                   (!first_q && ef_bf_q && c.be_bf)) begin
        rem_d    = 2'd0;
        first_d  = 1'b0;
        lead_d   = SPEC_NONE;
        ef_bf_d  = 1'b0;
        failed_d = 1'b1;
      end else begin
        if (first_q) begin
          ef_bf_d = (lead_q == SPEC_EF) && c.is_bf;
          first_d = 1'b0;
        end else begin
          ef_bf_d = 1'b0;
        end
        rem_d = rem_q - 2'd1;
        if (rem_q == 2'd1) begin
          lead_d  = SPEC_NONE;
          first_d = 1'b0;
          ef_bf_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= 2'd0;
      first_q     <= 1'b0;
      lead_q      <= SPEC_NONE;
      ef_bf_q     <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      first_q     <= first_d;
      lead_q      <= lead_d;
      ef_bf_q     <= ef_bf_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    string_valid_q <= string_valid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign string_valid_o = string_valid_q;

endmodule

`default_nettype wire

// ----- tb/utf8_string_validator_unit_tb.sv -----
// Self-checking testbench for the strict UTF-8 string validator, with a verdict scoreboard.
`timescale 1ns / 1ps

module utf8_string_validator_unit_tb;

  localparam int unsigned LiveByteTarget = 1850;
  localparam int unsigned LongHoldCycles = 100;
  localparam int unsigned DirectedCount  = 37;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       string_valid_o;

  utf8_string_validator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_value_i  (byte_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .string_valid_o(string_valid_o)
  );

  class verdict_scoreboard;
    bit [1:0] cont_left;
    bit       first_cont;
    bit [7:0] lead;
    bit       ef_bf_seen;
    bit       broken;
    bit       expected_verdicts[$];

    function void clear_sequence();
      cont_left  = 2'd0;
      first_cont = 1'b0;
      lead       = 8'h00;
      ef_bf_seen = 1'b0;
    endfunction

    function void fail_string();
      clear_sequence();
      broken = 1'b1;
    endfunction

    function void take_lead(bit [7:0] b);
      if (b < 8'h80) return;
      if (b[7:5] == 3'b110) begin
        if (b[7:1] == 7'b1100000) begin
          fail_string();
          return;
        end
        cont_left = 2'd1;
      end else if (b[7:4] == 4'he) begin
        cont_left = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        if (b > 8'hf4) begin
          fail_string();
          return;
        end
        cont_left = 2'd3;
      end else begin
        fail_string();
        return;
      end
      lead       = b;
      first_cont = 1'b1;
      ef_bf_seen = 1'b0;
    endfunction

    function void take_cont(bit [7:0] b);
      bit bad;
      bad = 1'b0;
      if (b[7:6] != 2'b10) begin
        fail_string();
        return;
      end
      if (first_cont) begin
        if (lead == 8'he0 && b[7:5] == 3'b100) bad = 1'b1;
        if (lead == 8'hed && b[7:5] == 3'b101) bad = 1'b1;
        if (lead == 8'hf0 && b[7:4] == 4'h8) bad = 1'b1;
        if (lead == 8'hf4 && b > 8'h8f) bad = 1'b1;
        if (bad) begin
          fail_string();
          return;
        end
        ef_bf_seen = (lead == 8'hef && b == 8'hbf);
        first_cont = 1'b0;
      end else if (ef_bf_seen) begin
        if (b[7:1] == 7'b1011111) begin
          fail_string();
          return;
        end
        ef_bf_seen = 1'b0;
      end
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) clear_sequence();
    endfunction

    function void note_byte(bit [7:0] b);
      if (b == 8'h00) begin
        expected_verdicts.push_back(!broken && cont_left == 2'd0);
        clear_sequence();
        broken = 1'b0;
      end else if (!broken) begin
        if (cont_left == 2'd0) take_lead(b);
        else take_cont(b);
      end
    endfunction

    function string check_verdict(bit got);
      bit want;
      if (expected_verdicts.size() == 0)
        return $sformatf("string_valid_o=%0b with no verdict expected", got);
      want = expected_verdicts.pop_front();
      if (got != want) return $sformatf("string_valid_o got %0b, expected %0b", got, want);
      return "";
    endfunction

    function int unsigned outstanding();
      return expected_verdicts.size();
    endfunction
  endclass

  verdict_scoreboard board;
  int unsigned       mismatches;
  int unsigned       live_bytes;
  bit                long_hold_req;
  logic [7:0]        string_bytes[$];
  logic [7:0]        directed_bytes [DirectedCount] = '{
    8'h00,
    8'h7f, 8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'h00,
    8'hc1, 8'hbf, 8'h00,
    8'he0, 8'h9f, 8'h00,
    8'hed, 8'ha0, 8'h00,
    8'hef, 8'hbf, 8'hbf, 8'h00,
    8'hf4, 8'h90, 8'h00,
    8'hf0, 8'h8f, 8'h00,
    8'hc3, 8'h41, 8'h00,
    8'he4, 8'h00,
    8'h80, 8'hff, 8'h00,
    8'hf5, 8'h41, 8'h00
  };

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_range(int lo, int hi);
    string_bytes.push_back(8'($urandom_range(hi, lo)));
  endfunction

  function automatic void push_good_char();
    case ($urandom_range(0, 8))
      0, 1: push_range(8'h01, 8'h7f);
      2: begin
        push_range(8'hc2, 8'hdf);
        push_range(8'h80, 8'hbf);
      end
      3: begin
        string_bytes.push_back(8'he0);
        push_range(8'ha0, 8'hbf);
        push_range(8'h80, 8'hbf);
      end
      4: begin
        if ($urandom_range(0, 1)) push_range(8'he1, 8'hec);
        else push_range(8'hee, 8'hef);
        push_range(8'h80, 8'hbf);
        push_range(8'h80, 8'hbf);
      end
      5: begin
        string_bytes.push_back(8'hed);
        push_range(8'h80, 8'h9f);
        push_range(8'h80, 8'hbf);
      end
      6: begin
        case ($urandom_range(0, 2))
          0: begin
            string_bytes.push_back(8'hf0);
            push_range(8'h90, 8'hbf);
          end
          1: begin
            push_range(8'hf1, 8'hf3);
            push_range(8'h80, 8'hbf);
          end
          default: begin
            string_bytes.push_back(8'hf4);
            push_range(8'h80, 8'h8f);
          end
        endcase
        push_range(8'h80, 8'hbf);
        push_range(8'h80, 8'hbf);
      end
      7: begin
        string_bytes.push_back(8'hef);
        string_bytes.push_back(8'hbf);
        push_range(8'hb8, 8'hbf);
      end
      default: begin
        string_bytes.push_back(8'hef);
        push_range(8'hbe, 8'hbf);
        push_range(8'hbe, 8'hbf);
      end
    endcase
  endfunction

  function automatic void push_noise();
    case ($urandom_range(0, 3))
      0: push_range(8'h01, 8'hff);
      1: push_range(8'h80, 8'hbf);
      2: begin
        if ($urandom_range(0, 1)) push_range(8'hc0, 8'hc1);
        else push_range(8'hf5, 8'hff);
      end
      default: push_range(8'hc2, 8'hf4);
    endcase
  endfunction

  function automatic void build_string();
    int chars;
    string_bytes.delete();
    chars = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    if ($urandom_range(0, 9) == 0) begin
      repeat (chars) push_range(8'h01, 8'hff);
    end else begin
      repeat (chars) begin
        if ($urandom_range(0, 99) < 8) push_noise();
        else push_good_char();
      end
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    byte_value_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    live_bytes++;
    board.note_byte(b);
  endtask

  task automatic send_string();
    bit calm;
    calm = ($urandom_range(0, 4) == 0);
    foreach (string_bytes[i]) send_byte(string_bytes[i], calm ? 0 : pick_gap());
    send_byte(8'h00, calm ? 0 : pick_gap());
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg = board.check_verdict(string_valid_o);
      if (msg != "") report_mismatch(msg);
    end
  end

  initial begin : receiver
    int stall_left;
    int quiet_left;
    stall_left  = 0;
    quiet_left  = 0;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHoldCycles - 1) @(negedge clk_i);
        long_hold_req = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else if (quiet_left > 0) begin
        out_stall_i <= 1'b0;
        quiet_left--;
      end else begin
        out_stall_i <= 1'b0;
        quiet_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : pick_gap();
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    board         = new;
    mismatches    = 0;
    live_bytes    = 0;
    long_hold_req = 1'b0;
    hold_done     = 1'b0;
    pause_done    = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    byte_value_i  = 8'h00;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_bytes[i]) send_byte(directed_bytes[i], pick_gap());
    wait_for_verdicts();

    while (live_bytes < LiveByteTarget) begin
      if (!hold_done && live_bytes > 600) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!pause_done && live_bytes > 1200) begin
        wait_for_verdicts();
        pause_done = 1'b1;
      end
      build_string();
      send_string();
    end

    wait_for_verdicts();
    repeat (10) @(posedge clk_i);
    if (board.outstanding() != 0)
      report_mismatch($sformatf("%0d verdicts never arrived", board.outstanding()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/usv_pkg.sv
design/usv_classify.sv
design/usv_queue.sv
design/usv_check.sv
design/utf8_string_validator_unit.sv
tb/utf8_string_validator_unit_tb.sv
